// ===== sv/bee_pkg.sv =====
// Shared types, codes and helper function of the boolean expression evaluator.
package bee_pkg;

  // Default operator and value stack depth.
  localparam int unsigned STACK_DEPTH_DEF = 32;

  // Width of each operand set.
  localparam int unsigned SET_W = 26;

  // Operator codes as held on the operator stack.
  localparam logic [1:0] OP_LPAREN = 2'd0;
  localparam logic [1:0] OP_NOT    = 2'd1;
  localparam logic [1:0] OP_AND    = 2'd2;
  localparam logic [1:0] OP_OR     = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SYNTAX  = 2'd1;
  localparam logic [1:0] ST_NEITHER = 2'd2;
  localparam logic [1:0] ST_BOTH    = 2'd3;

  // Character codes that the parser recognises.
  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] CH_NOT     = 8'h21;
  localparam logic [7:0] CH_AND     = 8'h26;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_OR      = 8'h7c;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;

  // Character classes.
  typedef enum logic [2:0] {
    CLS_BLANK,
    CLS_LETTER,
    CLS_OPEN,
    CLS_NOT,
    CLS_CLOSE,
    CLS_AND,
    CLS_OR,
    CLS_OTHER
  } cls_e;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_LETTER,
    CMD_PUSH_OP,
    CMD_PUSH_BIN,
    CMD_APPLY,
    CMD_POP_PAREN,
    CMD_REFILL,
    CMD_SET_BAD,
    CMD_EMIT
  } cmd_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    cls_e cls;
    logic has_char;
    logic last_char;
    logic want_opnd;
    logic bad;
    logic op_empty;
    logic top_is_paren;
    logic top_ge;
    logic val_one;
    logic out_busy;
  } sts_t;

  // Binding strength of an operator code; the open parenthesis binds least.
  function automatic logic [1:0] prec(input logic [1:0] code);
    logic [1:0] p;
    case (code)
      OP_NOT:  p = 2'd3;
      OP_AND:  p = 2'd2;
      OP_OR:   p = 2'd1;
      default: p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/bee_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bee_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bee_datapath.sv =====
// Datapath: character latch, operator and value stacks, error flags and result register.
module bee_datapath #(
  parameter int unsigned STACK_DEPTH = bee_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bee_pkg::cmd_e               cmd_i,
  output bee_pkg::sts_t               sts_o,
  input  logic [bee_pkg::SET_W-1:0]   true_set_i,
  input  logic [bee_pkg::SET_W-1:0]   false_set_i,
  input  logic                        has_char_i,
  input  logic [7:0]                  char_code_i,
  input  logic                        last_char_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        value_o
);
  import bee_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  // Latched input transaction.
  logic       has_q, has_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;

  // Expression state. The top operator and the two top values live in flops;
  // the entries below them live in the stack RAMs.
  logic [CW-1:0] op_cnt_q, op_cnt_d;
  logic [1:0]    op_top_q, op_top_d;
  logic [CW-1:0] val_cnt_q, val_cnt_d;
  logic          v0_q, v0_d;
  logic          v1_q, v1_d;
  logic          refill_v_q, refill_v_d;
  logic          expect_q, expect_d;
  logic          bad_q, bad_d;
  logic [1:0]    ferr_q, ferr_d;

  // Result register.
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_status_q, out_status_d;
  logic       out_value_q, out_value_d;

  // Stack RAM ports.
  logic          op_we, val_we;
  logic [AW-1:0] op_waddr, op_raddr, val_waddr, val_raddr;
  logic [1:0]    op_wdata, op_rdata;
  logic          val_wdata, val_rdata;

  cls_e       cls;
  logic [7:0] ltr_diff;
  logic [4:0] ltr_idx;
  logic       lt, lf;
  logic [1:0] pend_code, push_code;

  bee_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_op_ram (
    .clk_i   (clk_i),
    .we_i    (op_we),
    .waddr_i (op_waddr),
    .wdata_i (op_wdata),
    .raddr_i (op_raddr),
    .rdata_o (op_rdata)
  );

  bee_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  // Classify the latched character.
  always_comb begin
    if (char_q == CH_BLANK) begin
      cls = CLS_BLANK;
    end else if (char_q inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      cls = CLS_LETTER;
    end else if (char_q == CH_LPAREN) begin
      cls = CLS_OPEN;
    end else if (char_q == CH_NOT) begin
      cls = CLS_NOT;
    end else if (char_q == CH_RPAREN) begin
      cls = CLS_CLOSE;
    end else if (char_q == CH_AND) begin
      cls = CLS_AND;
    end else if (char_q == CH_OR) begin
      cls = CLS_OR;
    end else begin
      cls = CLS_OTHER;
    end
  end

  // Operand lookup in both sets; only meaningful for letters.
  assign ltr_diff  = char_q - CH_LOWER_A;
  assign ltr_idx   = ltr_diff[4:0];
  assign lt        = true_set_i[ltr_idx];
  assign lf        = false_set_i[ltr_idx];
  assign pend_code = (char_q == CH_AND) ? OP_AND : OP_OR;
  assign push_code = (cmd_i == CMD_PUSH_BIN) ? pend_code :
                     ((char_q == CH_LPAREN) ? OP_LPAREN : OP_NOT);

  // Status for the controller.
  always_comb begin
    sts_o.cls          = cls;
    sts_o.has_char     = has_q;
    sts_o.last_char    = last_q;
    sts_o.want_opnd    = expect_q;
    sts_o.bad          = bad_q;
    sts_o.op_empty     = (op_cnt_q == '0);
    sts_o.top_is_paren = (op_top_q == OP_LPAREN);
    sts_o.top_ge       = (op_top_q != OP_LPAREN) && (prec(op_top_q) >= prec(pend_code));
    sts_o.val_one      = (val_cnt_q == CW'(1));
    sts_o.out_busy     = out_valid_q && out_stall_i;
  end

  // Command execution.
  always_comb begin
    has_d        = has_q;
    char_d       = char_q;
    last_d       = last_q;
    op_cnt_d     = op_cnt_q;
    op_top_d     = op_top_q;
    val_cnt_d    = val_cnt_q;
    v0_d         = v0_q;
    v1_d         = v1_q;
    refill_v_d   = refill_v_q;
    expect_d     = expect_q;
    bad_d        = bad_q;
    ferr_d       = ferr_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    op_we        = 1'b0;
    op_waddr     = AW'(op_cnt_q - CW'(1));
    op_wdata     = op_top_q;
    op_raddr     = (op_cnt_q >= CW'(2)) ? AW'(op_cnt_q - CW'(2)) : '0;
    val_we       = 1'b0;
    val_waddr    = AW'(val_cnt_q - CW'(2));
    val_wdata    = v1_q;
    val_raddr    = (val_cnt_q >= CW'(3)) ? AW'(val_cnt_q - CW'(3)) : '0;

    case (cmd_i)
      CMD_LATCH: begin
        has_d  = has_char_i;
        char_d = char_code_i;
        last_d = last_char_i;
      end
      CMD_LETTER: begin
        if (!expect_q) begin
          bad_d = 1'b1;
        end else begin
          if (ferr_q == ST_OK) begin
            if (!lt && !lf) begin
              ferr_d = ST_NEITHER;
            end else if (lt && lf) begin
              ferr_d = ST_BOTH;
            end
          end
          if (val_cnt_q >= FULL) begin
            bad_d = 1'b1;
          end else begin
            val_we    = (val_cnt_q >= CW'(2));
            v1_d      = v0_q;
            v0_d      = lt && !lf;
            val_cnt_d = val_cnt_q + CW'(1);
          end
          expect_d = 1'b0;
        end
      end
      CMD_PUSH_OP, CMD_PUSH_BIN: begin
        if (cmd_i == CMD_PUSH_OP && !expect_q) begin
          bad_d = 1'b1;
        end else if (op_cnt_q >= FULL) begin
          bad_d = 1'b1;
        end else begin
          op_we    = (op_cnt_q != '0);
          op_top_d = push_code;
          op_cnt_d = op_cnt_q + CW'(1);
        end
        if (cmd_i == CMD_PUSH_BIN) begin
          expect_d = 1'b1;
        end
      end
      CMD_APPLY: begin
        // Pop the top operator; the entry below it comes back on refill.
        op_cnt_d   = op_cnt_q - CW'(1);
        refill_v_d = 1'b0;
        if (op_top_q == OP_NOT) begin
          if (val_cnt_q == '0) begin
            bad_d = 1'b1;
          end else begin
            v0_d = ~v0_q;
          end
        end else if (op_top_q == OP_LPAREN || val_cnt_q < CW'(2)) begin
          bad_d = 1'b1;
        end else begin
          v0_d       = (op_top_q == OP_AND) ? (v1_q & v0_q) : (v1_q | v0_q);
          val_cnt_d  = val_cnt_q - CW'(1);
          refill_v_d = 1'b1;
        end
      end
      CMD_POP_PAREN: begin
        op_cnt_d   = op_cnt_q - CW'(1);
        refill_v_d = 1'b0;
      end
      CMD_REFILL: begin
        op_top_d = op_rdata;
        if (refill_v_q) begin
          v1_d = val_rdata;
        end
      end
      CMD_SET_BAD: begin
        bad_d = 1'b1;
      end
      CMD_EMIT: begin
        out_valid_d  = 1'b1;
        out_status_d = bad_q ? ST_SYNTAX : ferr_q;
        out_value_d  = (!bad_q && ferr_q == ST_OK) ? v0_q : 1'b0;
        op_cnt_d     = '0;
        val_cnt_d    = '0;
        expect_d     = 1'b1;
        bad_d        = 1'b0;
        ferr_d       = ST_OK;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_cnt_q    <= '0;
      val_cnt_q   <= '0;
      refill_v_q  <= 1'b0;
      expect_q    <= 1'b1;
      bad_q       <= 1'b0;
      ferr_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      op_cnt_q    <= op_cnt_d;
      val_cnt_q   <= val_cnt_d;
      refill_v_q  <= refill_v_d;
      expect_q    <= expect_d;
      bad_q       <= bad_d;
      ferr_q      <= ferr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    has_q        <= has_d;
    char_q       <= char_d;
    last_q       <= last_d;
    op_top_q     <= op_top_d;
    v0_q         <= v0_d;
    v1_q         <= v1_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_o     = out_value_q;

  // The stack counts never pass the stack depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_cnt_q <= FULL && val_cnt_q <= FULL)
    else $error("stack count beyond depth");

  // Loading a result leaves a clean expression state behind it.
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_EMIT |=> out_valid_q && op_cnt_q == '0 && val_cnt_q == '0
                          && expect_q && !bad_q && ferr_q == ST_OK)
    else $error("result load did not clear the expression state");

  // A result in the output register waits while it is stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && cmd_i != CMD_EMIT |=> out_valid_q)
    else $error("stalled result dropped");

endmodule

// ===== sv/bee_ctrl.sv =====
// Controller: sequences decode, operator reduction, stack refill and result load.
module bee_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bee_pkg::sts_t sts_i,
  output bee_pkg::cmd_e cmd_o
);
  import bee_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHAR   = 3'd1;
  localparam logic [2:0] S_REDUCE = 3'd2;
  localparam logic [2:0] S_REFILL = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  // What the reduction loop is working for.
  localparam logic [1:0] MODE_CLOSE = 2'd0;
  localparam logic [1:0] MODE_BIN   = 2'd1;
  localparam logic [1:0] MODE_FIN   = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] mode_q, mode_d;
  logic       cont_q, cont_d;

  // Next state and command.
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cont_d  = cont_q;
    cmd_o   = CMD_NONE;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LATCH;
          state_d = S_CHAR;
        end
      end
      S_CHAR: begin
        state_d = S_DONE;
        if (sts_i.has_char && !sts_i.bad) begin
          case (sts_i.cls)
            CLS_BLANK: begin
            end
            CLS_LETTER: begin
              cmd_o = CMD_LETTER;
            end
            CLS_OPEN, CLS_NOT: begin
              cmd_o = CMD_PUSH_OP;
            end
            CLS_CLOSE: begin
              if (sts_i.want_opnd) begin
                cmd_o = CMD_SET_BAD;
              end else begin
                mode_d  = MODE_CLOSE;
                state_d = S_REDUCE;
              end
            end
            CLS_AND, CLS_OR: begin
              if (sts_i.want_opnd) begin
                cmd_o = CMD_SET_BAD;
              end else begin
                mode_d  = MODE_BIN;
                state_d = S_REDUCE;
              end
            end
            default: begin
              cmd_o = CMD_SET_BAD;
            end
          endcase
        end
      end
      S_REDUCE: begin
        if (sts_i.bad) begin
          state_d = (mode_q == MODE_FIN) ? S_OUT : S_DONE;
        end else begin
          case (mode_q)
            MODE_CLOSE: begin
              if (sts_i.op_empty) begin
                cmd_o   = CMD_SET_BAD;
                state_d = S_DONE;
              end else if (sts_i.top_is_paren) begin
                cmd_o   = CMD_POP_PAREN;
                cont_d  = 1'b0;
                state_d = S_REFILL;
              end else begin
                cmd_o   = CMD_APPLY;
                cont_d  = 1'b1;
                state_d = S_REFILL;
              end
            end
            MODE_BIN: begin
              if (!sts_i.op_empty && sts_i.top_ge) begin
                cmd_o   = CMD_APPLY;
                cont_d  = 1'b1;
                state_d = S_REFILL;
              end else begin
                cmd_o   = CMD_PUSH_BIN;
                state_d = S_DONE;
              end
            end
            default: begin
              if (sts_i.op_empty) begin
                if (!sts_i.val_one) begin
                  cmd_o = CMD_SET_BAD;
                end
                state_d = S_OUT;
              end else if (sts_i.top_is_paren) begin
                cmd_o   = CMD_SET_BAD;
                state_d = S_OUT;
              end else begin
                cmd_o   = CMD_APPLY;
                cont_d  = 1'b1;
                state_d = S_REFILL;
              end
            end
          endcase
        end
      end
      S_REFILL: begin
        cmd_o   = CMD_REFILL;
        state_d = cont_q ? S_REDUCE : S_DONE;
      end
      S_DONE: begin
        if (!sts_i.last_char) begin
          state_d = S_IDLE;
        end else if (sts_i.bad) begin
          state_d = S_OUT;
        end else if (sts_i.want_opnd) begin
          cmd_o   = CMD_SET_BAD;
          state_d = S_OUT;
        end else begin
          mode_d  = MODE_FIN;
          state_d = S_REDUCE;
        end
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o   = CMD_EMIT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_CLOSE;
      cont_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cont_q  <= cont_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // An accepted transaction is decoded in the next cycle.
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_CHAR)
    else $error("accepted transaction not decoded");

  // A stack refill only follows a pop issued by the reduction loop.
  a_refill_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REFILL |-> $past(state_q) == S_REDUCE
                            && ($past(cmd_o) == CMD_APPLY || $past(cmd_o) == CMD_POP_PAREN))
    else $error("refill without a preceding pop");

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o == CMD_EMIT |-> !sts_i.out_busy)
    else $error("result loaded over a waiting result");

endmodule

// ===== sv/boolean_expression_evaluator.sv =====
// Top level of the streaming boolean expression evaluator with its register port.
//
// The block reads an infix boolean expression one character per transaction
// (letters a to z, prefix '!', then '&', then '|', parentheses, blanks) and,
// on the transaction that carries last_char, delivers one status and value.
// A blank, a letter, '(', '!', an empty transaction, a misplaced character or
// any character after a syntax error goes through accept, decode and wrap-up.
// An '&' or '|' after an operand adds, for each operator that it reduces, an
// apply step and a reload of the stack tops from the registered-read stack
// RAMs, then a step that pushes it; a matched ')' adds the same apply and
// reload per reduced operator, then a pop of its '(' with its own reload. On
// the transaction that carries last_char, an expression that is already bad
// or ends on an operator adds a result load; any other adds an apply and a
// reload per operator left on the stack, then a check of the stacks and the
// result load. The input stalls once a transaction is accepted until that
// sequence is over. A result that is still waiting holds up only the final
// transaction of the next expression, in its result-load cycle. The stacks
// need no clearing after reset. Registers: true_set at byte address 0 and
// false_set at byte address 4, 26 bits each.
module boolean_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = bee_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        has_char_i,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bee_pkg::*;

  logic [SET_W-1:0] true_set_q, false_set_q;
  logic             cfg_we;
  cmd_e             cmd;
  sts_t             sts;

  // Register writes complete in the access phase.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      true_set_q  <= '0;
      false_set_q <= '0;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        false_set_q <= pwdata[SET_W-1:0];
      end else begin
        true_set_q <= pwdata[SET_W-1:0];
      end
    end
  end

  // Register read-back.
  assign prdata = paddr[2] ? {{(32 - SET_W){1'b0}}, false_set_q}
                           : {{(32 - SET_W){1'b0}}, true_set_q};

  bee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .true_set_i  (true_set_q),
    .false_set_i (false_set_q),
    .has_char_i  (has_char_i),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .value_o     (value_o)
  );

endmodule

// ===== test/boolean_expression_evaluator_tb.sv =====
// Self-checking testbench of the streaming boolean expression evaluator.
module boolean_expression_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bee_pkg::*;

  localparam int unsigned DEPTH        = STACK_DEPTH_DEF;
  localparam int unsigned REG_TRUE_SET  = 0;
  localparam int unsigned REG_FALSE_SET = 1;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_ITEMS  = 190;
  localparam logic [SET_W-1:0] ALL_SET = '1;

  // One expected or observed result transaction.
  typedef struct packed {
    logic [1:0] status;
    logic       value;
  } verdict_t;

  // Scoreboard: mirrors the evaluation of each expression and keeps the verdicts still owed.
  class evaluator_scoreboard;
    logic [SET_W-1:0] true_bits;
    logic [SET_W-1:0] false_bits;
    logic [1:0]       ops [DEPTH];
    bit               vals [DEPTH];
    int unsigned      op_top;
    int unsigned      val_top;
    bit               awaiting_operand;
    bit               syntax_fault;
    logic [1:0]       first_bad;
    verdict_t         verdict_q[$];
    int unsigned      errors;

    function new();
      true_bits  = '0;
      false_bits = '0;
      errors     = 0;
      clear_expression();
    endfunction

    function void clear_expression();
      op_top           = 0;
      val_top          = 0;
      awaiting_operand = 1'b1;
      syntax_fault     = 1'b0;
      first_bad        = ST_OK;
    endfunction

    function void set_register(int unsigned idx, logic [SET_W-1:0] bits);
      if (idx == REG_TRUE_SET) begin
        true_bits = bits;
      end else if (idx == REG_FALSE_SET) begin
        false_bits = bits;
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    // Binding strength; an open parenthesis never gets reduced by precedence.
    function int unsigned binding(logic [1:0] code);
      case (code)
        OP_NOT:  return 3;
        OP_AND:  return 2;
        OP_OR:   return 1;
        default: return 0;
      endcase
    endfunction

    function void push_val(bit v);
      if (val_top >= DEPTH) begin
        syntax_fault = 1'b1;
        return;
      end
      vals[val_top] = v;
      val_top++;
    endfunction

    function void push_op(logic [1:0] code);
      if (op_top >= DEPTH) begin
        syntax_fault = 1'b1;
        return;
      end
      ops[op_top] = code;
      op_top++;
    endfunction

    // Pops the top operator and applies it to the value stack.
    function void apply_top();
      logic [1:0] code;
      bit         a;
      bit         b;
      if (op_top == 0) begin
        syntax_fault = 1'b1;
        return;
      end
      op_top--;
      code = ops[op_top];
      if (code == OP_NOT) begin
        if (val_top < 1) begin
          syntax_fault = 1'b1;
          return;
        end
        vals[val_top - 1] = !vals[val_top - 1];
        return;
      end
      if (code == OP_LPAREN || val_top < 2) begin
        syntax_fault = 1'b1;
        return;
      end
      val_top--;
      b = vals[val_top];
      val_top--;
      a = vals[val_top];
      push_val(code == OP_AND ? (a & b) : (a | b));
    endfunction

    function void absorb_char(logic [7:0] ch);
      int unsigned n;
      bit          t;
      bit          f;
      logic [1:0]  code;
      if (ch == CH_BLANK) return;
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
        n = ch - CH_LOWER_A;
        t = true_bits[n];
        f = false_bits[n];
        if (!awaiting_operand) begin
          syntax_fault = 1'b1;
          return;
        end
        // Only the first undefined or contradictory operand decides the status.
        if (first_bad == ST_OK) begin
          if (!t && !f) begin
            first_bad = ST_NEITHER;
          end else if (t && f) begin
            first_bad = ST_BOTH;
          end
        end
        push_val(t && !f);
        awaiting_operand = 1'b0;
      end else if (ch == CH_LPAREN || ch == CH_NOT) begin
        if (!awaiting_operand) begin
          syntax_fault = 1'b1;
          return;
        end
        push_op(ch == CH_LPAREN ? OP_LPAREN : OP_NOT);
      end else if (ch == CH_RPAREN) begin
        if (awaiting_operand) begin
          syntax_fault = 1'b1;
          return;
        end
        while (!syntax_fault && op_top > 0 && ops[op_top - 1] != OP_LPAREN) apply_top();
        if (syntax_fault) return;
        if (op_top == 0) begin
          syntax_fault = 1'b1;
          return;
        end
        op_top--;
      end else if (ch == CH_AND || ch == CH_OR) begin
        code = (ch == CH_AND) ? OP_AND : OP_OR;
        if (awaiting_operand) begin
          syntax_fault = 1'b1;
          return;
        end
        while (!syntax_fault && op_top > 0 && ops[op_top - 1] != OP_LPAREN &&
               binding(ops[op_top - 1]) >= binding(code)) apply_top();
        if (syntax_fault) return;
        push_op(code);
        awaiting_operand = 1'b1;
      end else begin
        syntax_fault = 1'b1;
      end
    endfunction

    // Reduces whatever is left once the expression has ended.
    function void close_expression();
      if (syntax_fault) return;
      if (awaiting_operand) begin
        syntax_fault = 1'b1;
        return;
      end
      while (!syntax_fault && op_top > 0) begin
        if (ops[op_top - 1] == OP_LPAREN) begin
          syntax_fault = 1'b1;
          return;
        end
        apply_top();
      end
      if (val_top != 1) syntax_fault = 1'b1;
    endfunction

    // Notes an accepted input transaction and queues the verdict it causes.
    function void note_item(bit has, logic [7:0] ch, bit last);
      verdict_t v;
      if (has && !syntax_fault) absorb_char(ch);
      if (!last) return;
      close_expression();
      v.status = syntax_fault ? ST_SYNTAX : first_bad;
      v.value  = (v.status == ST_OK) ? vals[0] : 1'b0;
      verdict_q.push_back(v);
      clear_expression();
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Compares an accepted result transaction with the oldest verdict owed.
    task check_result(logic [1:0] status, logic value);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        report($sformatf("result status=%0d value=%0d arrived with none owed", status, value));
        return;
      end
      want = verdict_q.pop_front();
      if (status !== want.status) begin
        report($sformatf("status %0d, expected %0d", status, want.status));
      end
      if (value !== want.value) begin
        report($sformatf("value %0d, expected %0d", value, want.value));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        has_char_i  = 1'b0;
  logic [7:0]  char_code_i = '0;
  logic        last_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic        value_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  evaluator_scoreboard sb = new();
  logic [7:0]  expr_q[$];
  bit          gaps_on;
  int unsigned items_sent;

  boolean_expression_evaluator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .has_char_i  (has_char_i),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .value_o     (value_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result monitor: every accepted result transaction is checked.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(status_o, value_o);
  end

  // Result back-pressure: short stalls, a few long ones, and free stretches.
  initial begin : out_stall_gen
    int unsigned r;
    int unsigned run;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        out_stall_i <= 1'b0;
        run = $urandom_range(20, 80);
      end else if (r < 50) begin
        out_stall_i <= 1'b0;
        run = $urandom_range(1, 4);
      end else if (r < 92) begin
        out_stall_i <= 1'b1;
        run = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        run = $urandom_range(8, 40);
      end
      repeat (run) @(posedge clk_i);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [7:0] random_letter();
    return CH_LOWER_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_token();
    case ($urandom_range(0, 7))
      0:       return CH_BLANK;
      1:       return CH_NOT;
      2:       return CH_AND;
      3:       return CH_OR;
      4:       return CH_LPAREN;
      5:       return CH_RPAREN;
      6:       return random_letter();
      default: return 8'($urandom);
    endcase
  endfunction

  // Builds a well-formed expression with the given number of operands into expr_q.
  function automatic void build_wellformed(int unsigned operands, int unsigned max_depth);
    int unsigned depth;
    int unsigned left;
    bit          want;
    depth = 0;
    left  = operands;
    want  = 1'b1;
    expr_q.delete();
    forever begin
      if ($urandom_range(0, 9) == 0) expr_q.push_back(CH_BLANK);
      if (want) begin
        case ($urandom_range(0, 5))
          0: expr_q.push_back(CH_NOT);
          1: begin
            if (depth < max_depth && left > 0) begin
              expr_q.push_back(CH_LPAREN);
              depth++;
            end
          end
          default: begin
            expr_q.push_back(random_letter());
            want = 1'b0;
            if (left > 0) left--;
          end
        endcase
      end else if (left == 0 && depth == 0) begin
        break;
      end else if (depth > 0 && (left == 0 || $urandom_range(0, 3) == 0)) begin
        expr_q.push_back(CH_RPAREN);
        depth--;
      end else begin
        expr_q.push_back($urandom_range(0, 1) ? CH_AND : CH_OR);
        want = 1'b1;
      end
    end
  endfunction

  // Breaks a sequence by replacing, dropping or inserting one character.
  function automatic void corrupt_expression();
    int unsigned pos;
    if (expr_q.size() == 0) begin
      expr_q.push_back(random_token());
      return;
    end
    pos = $urandom_range(0, expr_q.size() - 1);
    case ($urandom_range(0, 3))
      0:       expr_q[pos] = 8'($urandom);
      1:       expr_q[pos] = random_token();
      2:       expr_q.delete(pos);
      default: expr_q.insert(pos, random_token());
    endcase
  endfunction

  // Presents one input transaction and waits until the block takes it.
  task automatic send_item(input bit has, input logic [7:0] ch, input bit last);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    has_char_i  <= has;
    char_code_i <= ch;
    last_char_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(has, ch, last);
  endtask

  // Sends expr_q as one expression, ended on its last character or by an empty transaction.
  task automatic send_expression();
    bit own_end;
    own_end = (expr_q.size() == 0) || ($urandom_range(0, 7) == 0);
    gaps_on = ($urandom_range(0, 3) != 0);
    foreach (expr_q[i]) begin
      // An empty transaction without last_char must leave the expression untouched.
      if ($urandom_range(0, 15) == 0) send_item(1'b0, 8'($urandom), 1'b0);
      send_item(1'b1, expr_q[i], !own_end && (i == expr_q.size() - 1));
      items_sent++;
    end
    if (own_end) begin
      send_item(1'b0, 8'($urandom), 1'b1);
      items_sent++;
    end
  endtask

  task automatic send_text(input string s);
    expr_q.delete();
    for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
    send_expression();
  endtask

  // Mostly well-formed expressions; some deep nesting, broken sequences and noise.
  task automatic random_expression();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      expr_q.delete();
      repeat ($urandom_range(1, 6)) expr_q.push_back(random_token());
    end else begin
      build_wellformed(($urandom_range(0, 6) == 0) ? $urandom_range(7, 20)
                                                    : $urandom_range(1, 6),
                       $urandom_range(0, 4));
      if (r < 7) begin
        // Nesting around the stack depth, to reach the overflow.
        k = $urandom_range(28, 36);
        repeat (k) begin
          expr_q.push_front(CH_LPAREN);
          expr_q.push_back(CH_RPAREN);
        end
      end else if (r < 9) begin
        k = $urandom_range(28, 36);
        repeat (k) expr_q.push_front(CH_NOT);
      end else if (r < 24) begin
        corrupt_expression();
      end
    end
    send_expression();
  endtask

  task automatic apb_write(input int unsigned idx, input logic [SET_W-1:0] bits);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= {6'($urandom), bits};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, bits);
  endtask

  task automatic set_registers(input logic [SET_W-1:0] t, input logic [SET_W-1:0] f);
    apb_write(REG_TRUE_SET, t);
    apb_write(REG_FALSE_SET, f);
  endtask

  // Waits until every verdict has arrived and the block has settled.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Main sequence: reset, directed expressions, then random phases.
  initial begin : stimulus
    logic [SET_W-1:0] t;
    logic [SET_W-1:0] f;
    items_sent = 0;
    gaps_on    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Letters a to k true, l to y false, z in neither.
    set_registers(26'h00007FF, 26'h1FFF800);
    send_text("a");
    send_text("!!m");
    send_text("a|m&!a");
    send_text("l|z");
    send_text("");
    send_text("a&");
    send_text("()");
    expr_q.delete();
    expr_q.push_back(8'hFF);
    send_expression();
    send_text(")");
    send_text("(a");
    send_text("ab");
    send_text(" ");

    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      t = SET_W'($urandom);
      f = ~t;
      case (p)
        1: begin
          t = ALL_SET;
          f = '0;
        end
        3: begin
          t = '0;
          f = ALL_SET;
        end
        4: begin
          t = ALL_SET;
          f = ALL_SET;
        end
        6: begin
          t = '0;
          f = '0;
        end
        2, 7: begin
          // A few letters left undefined or made contradictory.
          t[$urandom_range(0, SET_W - 1)] ^= 1'b1;
          f[$urandom_range(0, SET_W - 1)] ^= 1'b1;
        end
        default: ;
      endcase
      set_registers(t, f);
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) random_expression();
    end

    quiesce();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
